// File: src/bpat_pkg.sv
package bpat_pkg;

	// table size and derived widths
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int WORD_W = 32;
	localparam int COUNT_OUT_W = 5;

	// operation codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	// result status codes carried in the output tuser
	typedef enum logic [2:0] {
		ST_DONE = 3'd0,
		ST_GRANTED = 3'd1,
		ST_WRONG = 3'd2,
		ST_MISSING = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	// one table entry
	typedef struct packed {
		logic [WORD_W-1:0] badge;
		logic [WORD_W-1:0] code;
		logic [WORD_W-1:0] visit;
	} entry_t;

	// write request from the sequencer to the table
	typedef struct packed {
		logic we_badge;
		logic we_code;
		logic we_visit;
		logic [IDX_W-1:0] addr;
		entry_t data;
	} wr_req_t;

	// clear every byte after the first zero byte, scanning from the high byte
	function automatic logic [WORD_W-1:0] canon_word(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] keep;
		logic stop;
		keep = '0;
		stop = 1'b0;
		for (int b = 3; b >= 0; b--) begin
			if (w[b*8 +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				keep[b*8 +: 8] = w[b*8 +: 8];
			end
		end
		return keep;
	endfunction

endpackage

// File: src/badge_pin_access_table.sv
// badge_pin_access_table: ordered table of badge entries (badge, code, last visit)
// input channel s_*: tuser carries the operation (add, remove, change code,
// check access); tdata carries badge_id, pin_code and now_time. badge and code
// words are cut at their first zero byte before use.
// output channel m_*: one item per input item; tuser carries the status,
// tdata carries last_visit and entry_count.
// an add passes from the accept through S_RESP into the output register, and
// the sequencer is back in idle as that register loads. remove, change and
// check scan the table one entry per cycle through a single compare on the
// table read port, and a remove then moves each later entry down one slot
// per cycle. s_tready is high only between items.
// the result sits in an output register, so the next item is accepted while
// the previous result waits; a stalled receiver holds a finished item in the
// sequencer until the output register frees.
// reset clears the entry count and the handshake state; the table contents
// are not cleared, and only entries below the count are ever used.
module badge_pin_access_table (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [1:0] s_tuser,     // operation
	input logic [95:0] s_tdata,    // badge_id, pin_code, now_time
	output logic m_tvalid,
	input logic m_tready,
	output logic [2:0] m_tuser,    // status
	output logic [39:0] m_tdata    // last_visit, entry_count, zero fill
);

	logic [bpat_pkg::IDX_W-1:0] rd_addr;
	bpat_pkg::entry_t rd_entry;
	bpat_pkg::wr_req_t wr;

	// sequencer with the shared compare and the output register
	bpat_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry),
		.wr(wr)
	);

	// entry storage
	bpat_store u_store (
		.clk(clk),
		.wr(wr),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry)
	);

endmodule

// File: src/bpat_store.sv
module bpat_store (
	input logic clk,
	input bpat_pkg::wr_req_t wr,
	input logic [bpat_pkg::IDX_W-1:0] rd_addr,
	output bpat_pkg::entry_t rd_entry
);

	bpat_pkg::entry_t mem_q [bpat_pkg::TABLE_ENTRIES];
	bpat_pkg::entry_t rd_q;

	// per-field write into the addressed entry
	always_ff @(posedge clk) begin
		if (wr.we_badge) begin
			mem_q[wr.addr].badge <= wr.data.badge;
		end
		if (wr.we_code) begin
			mem_q[wr.addr].code <= wr.data.code;
		end
		if (wr.we_visit) begin
			mem_q[wr.addr].visit <= wr.data.visit;
		end
	end

	// registered read port, data for the presented address appears in the cycle after
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_entry = rd_q;

endmodule

// File: src/bpat_ctrl.sv
module bpat_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [1:0] s_tuser,     // operation
	input logic [95:0] s_tdata,    // badge_id, pin_code, now_time
	output logic m_tvalid,
	input logic m_tready,
	output logic [2:0] m_tuser,    // status
	output logic [39:0] m_tdata,   // last_visit, entry_count, zero fill
	output logic [bpat_pkg::IDX_W-1:0] rd_addr,
	input bpat_pkg::entry_t rd_entry,
	output bpat_pkg::wr_req_t wr
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_SHIFT = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	logic [bpat_pkg::CNT_W-1:0] idx_q;
	logic [bpat_pkg::CNT_W-1:0] count_q;
	bpat_pkg::op_t op_q;
	logic [bpat_pkg::WORD_W-1:0] badge_q;
	logic [bpat_pkg::WORD_W-1:0] code_q;
	logic [bpat_pkg::WORD_W-1:0] now_q;
	bpat_pkg::status_t res_status_q;
	logic [bpat_pkg::WORD_W-1:0] res_visit_q;
	logic out_valid_q;
	bpat_pkg::status_t out_status_q;
	logic [bpat_pkg::WORD_W-1:0] out_visit_q;
	logic [bpat_pkg::COUNT_OUT_W-1:0] out_count_q;

	logic accept;
	logic out_free;
	logic at_end;
	logic badge_hit;
	logic code_hit;
	logic shift_more;
	logic table_full;
	logic [bpat_pkg::CNT_W-1:0] idx_nxt;
	logic [bpat_pkg::CNT_W-1:0] idx_nxt2;
	bpat_pkg::op_t in_op;
	logic [bpat_pkg::WORD_W-1:0] in_badge;
	logic [bpat_pkg::WORD_W-1:0] in_code;
	logic [bpat_pkg::WORD_W-1:0] in_now;

	// input unpacking and canonical character words
	assign in_op = bpat_pkg::op_t'(s_tuser);
	assign in_badge = bpat_pkg::canon_word(s_tdata[31:0]);
	assign in_code = bpat_pkg::canon_word(s_tdata[63:32]);
	assign in_now = s_tdata[95:64];

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// shared compare against the entry under the scan pointer
	assign idx_nxt = idx_q + bpat_pkg::CNT_W'(1);
	assign idx_nxt2 = idx_q + bpat_pkg::CNT_W'(2);
	assign at_end = (idx_q == count_q);
	assign badge_hit = (rd_entry.badge == badge_q);
	assign code_hit = (rd_entry.code == code_q);
	assign shift_more = (idx_nxt < count_q);
	assign table_full = (count_q >= bpat_pkg::CNT_W'(bpat_pkg::TABLE_ENTRIES));

	// read address for the next cycle: scan entry, or the entry above the shift slot
	always_comb begin
		case (state_q)
			S_SCAN: begin
				rd_addr = idx_nxt[bpat_pkg::IDX_W-1:0];
			end
			S_SHIFT: begin
				rd_addr = idx_nxt2[bpat_pkg::IDX_W-1:0];
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// table write requests
	always_comb begin
		wr = '0;
		wr.addr = idx_q[bpat_pkg::IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && in_op == bpat_pkg::OP_ADD && !table_full) begin
					wr.we_badge = 1'b1;
					wr.we_code = 1'b1;
					wr.we_visit = 1'b1;
					wr.addr = count_q[bpat_pkg::IDX_W-1:0];
					wr.data.badge = in_badge;
					wr.data.code = in_code;
					wr.data.visit = in_now;
				end
			end
			S_SCAN: begin
				if (!at_end && badge_hit) begin
					wr.data.code = code_q;
					wr.data.visit = now_q;
					wr.we_code = (op_q == bpat_pkg::OP_CHANGE);
					wr.we_visit = (op_q == bpat_pkg::OP_CHECK) && code_hit;
				end
			end
			S_SHIFT: begin
				if (shift_more) begin
					wr.we_badge = 1'b1;
					wr.we_code = 1'b1;
					wr.we_visit = 1'b1;
					wr.data = rd_entry;
				end
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	// item capture, sequencer and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register load or drain
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (in_op == bpat_pkg::OP_ADD) begin
							state_q <= S_RESP;
							if (!table_full) begin
								count_q <= count_q + bpat_pkg::CNT_W'(1);
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (at_end) begin
						state_q <= S_RESP;
					end else if (badge_hit) begin
						state_q <= (op_q == bpat_pkg::OP_REMOVE) ? S_SHIFT : S_RESP;
					end else begin
						idx_q <= idx_nxt;
					end
				end
				S_SHIFT: begin
					if (shift_more) begin
						idx_q <= idx_nxt;
					end else begin
						count_q <= count_q - bpat_pkg::CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= in_op;
					badge_q <= in_badge;
					code_q <= in_code;
					now_q <= in_now;
					res_visit_q <= '0;
					if (in_op == bpat_pkg::OP_ADD && table_full) begin
						res_status_q <= bpat_pkg::ST_FULL;
					end else begin
						res_status_q <= bpat_pkg::ST_DONE;
					end
				end
			end
			S_SCAN: begin
				if (at_end) begin
					res_status_q <= bpat_pkg::ST_MISSING;
				end else if (badge_hit && op_q == bpat_pkg::OP_CHECK) begin
					if (code_hit) begin
						res_status_q <= bpat_pkg::ST_GRANTED;
						res_visit_q <= now_q;
					end else begin
						res_status_q <= bpat_pkg::ST_WRONG;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_visit_q <= res_visit_q;
					out_count_q <= bpat_pkg::COUNT_OUT_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	// output channel
	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {3'b000, out_count_q, out_visit_q};

endmodule

// File: tb/badge_pin_access_table_tb.sv
module badge_pin_access_table_tb;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 2 * bpat_pkg::TABLE_ENTRIES + 10;

	// expected outcome of one access request
	typedef struct {
		bpat_pkg::status_t status;
		logic [31:0] last_visit;
		logic [4:0] entry_count;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [1:0] s_tuser = bpat_pkg::OP_ADD;  // operation
	logic [95:0] s_tdata = '0;               // badge_id, pin_code, now_time
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2:0] m_tuser;                     // status
	logic [39:0] m_tdata;                    // last_visit, entry_count, zero fill

	// shadow copy of the badge table
	logic [31:0] table_badge [bpat_pkg::TABLE_ENTRIES];
	logic [31:0] table_code [bpat_pkg::TABLE_ENTRIES];
	logic [31:0] table_visit [bpat_pkg::TABLE_ENTRIES];
	int held_count = 0;

	access_result_t pending_results[$];
	logic [31:0] badge_pool [6];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	badge_pin_access_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// a word compares as a string: nothing after the first zero byte counts
	function automatic logic [31:0] strip_after_nul(input logic [31:0] raw);
		logic [31:0] word;
		word = raw;
		if (word[31:24] == 8'h00) word[23:0] = '0;
		if (word[23:16] == 8'h00) word[15:0] = '0;
		if (word[15:8] == 8'h00) word[7:0] = '0;
		return word;
	endfunction

	// random text word, often with a zero byte and junk after it
	function automatic logic [31:0] random_text_word();
		logic [31:0] word;
		word = $urandom;
		if ($urandom_range(3) == 0) word[$urandom_range(3)*8 +: 8] = 8'h00;
		return word;
	endfunction

	// fill the bytes after the first zero byte with junk
	function automatic logic [31:0] add_tail_junk(input logic [31:0] word);
		logic [31:0] raw;
		logic ended;
		raw = word;
		ended = 1'b0;
		for (int b = 3; b >= 0; b--) begin
			if (ended) raw[b*8 +: 8] = $urandom;
			else if (raw[b*8 +: 8] == 8'h00) ended = 1'b1;
		end
		return raw;
	endfunction

	// first entry holding the badge, or -1
	function automatic int find_entry(input logic [31:0] badge);
		for (int i = 0; i < held_count; i++) begin
			if (table_badge[i] == badge) return i;
		end
		return -1;
	endfunction

	// apply one request to the shadow table and queue the outcome
	task automatic apply_access(input bpat_pkg::op_t op, input logic [31:0] badge_raw,
			input logic [31:0] pin_raw, input logic [31:0] now);
		logic [31:0] badge;
		logic [31:0] pin;
		access_result_t res;
		int hit;
		badge = strip_after_nul(badge_raw);
		pin = strip_after_nul(pin_raw);
		res.status = bpat_pkg::ST_DONE;
		res.last_visit = '0;
		if (op == bpat_pkg::OP_ADD) begin
			if (held_count >= bpat_pkg::TABLE_ENTRIES) begin
				res.status = bpat_pkg::ST_FULL;
			end else begin
				table_badge[held_count] = badge;
				table_code[held_count] = pin;
				table_visit[held_count] = now;
				held_count++;
			end
		end else begin
			hit = find_entry(badge);
			if (hit < 0) begin
				res.status = bpat_pkg::ST_MISSING;
			end else if (op == bpat_pkg::OP_REMOVE) begin
				for (int i = hit; i + 1 < held_count; i++) begin
					table_badge[i] = table_badge[i+1];
					table_code[i] = table_code[i+1];
					table_visit[i] = table_visit[i+1];
				end
				held_count--;
			end else if (op == bpat_pkg::OP_CHANGE) begin
				table_code[hit] = pin;
			end else if (table_code[hit] == pin) begin
				table_visit[hit] = now;
				res.last_visit = now;
				res.status = bpat_pkg::ST_GRANTED;
			end else begin
				res.status = bpat_pkg::ST_WRONG;
			end
		end
		res.entry_count = held_count[4:0];
		pending_results.push_back(res);
	endtask

	// offer one item, wait for its acceptance, then predict it
	task automatic send_request(input bpat_pkg::op_t op, input logic [31:0] badge,
			input logic [31:0] pin, input logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now, pin, badge};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_access(op, badge, pin, now);
	endtask

	// stop offering until every outstanding result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_served) begin
			hold_served = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", m_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata[31:0] !== want.last_visit) begin
					$error("last_visit: expected %h, got %h", want.last_visit,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[36:32] !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						m_tdata[36:32]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// remove, change and check on an empty table
	task automatic test_missing_on_empty();
		send_request(bpat_pkg::OP_REMOVE, 32'h5858_0000, 32'h0, 32'h0);
		send_request(bpat_pkg::OP_CHANGE, 32'h5858_0000, 32'h3131_0000, 32'h1);
		send_request(bpat_pkg::OP_CHECK, 32'h5858_0000, 32'h3131_0000, 32'h2);
	endtask

	// duplicates act on the oldest entry; codes compare as strings
	task automatic test_duplicates_and_codes();
		send_request(bpat_pkg::OP_ADD, 32'h4142_0000, 32'h3132_3334, 32'h0000_0000);
		send_request(bpat_pkg::OP_ADD, 32'h4142_0000, 32'h3900_0000, 32'hFFFF_FFFF);
		send_request(bpat_pkg::OP_CHECK, 32'h4142_0000, 32'h3900_0000, 32'h0000_0010);
		send_request(bpat_pkg::OP_CHECK, 32'h4142_0000, 32'h3132_3334, 32'hFFFF_FFFF);
		send_request(bpat_pkg::OP_CHANGE, 32'h4142_0037, 32'h3900_ABCD, 32'h0000_0020);
		send_request(bpat_pkg::OP_CHECK, 32'h4142_00FF, 32'h3900_1234, 32'h8000_0001);
	endtask

	// empty string and all-ones words
	task automatic test_word_extremes();
		send_request(bpat_pkg::OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'h5555_5555);
		send_request(bpat_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		send_request(bpat_pkg::OP_CHECK, 32'h00FF_FFFF, 32'h0012_3456, 32'h7FFF_FFFF);
		send_request(bpat_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h0000_0001);
	endtask

	// removal from the front, fill to capacity, add when full
	task automatic test_table_full();
		send_request(bpat_pkg::OP_REMOVE, 32'h4142_0000, 32'h0, 32'h0);
		while (held_count < bpat_pkg::TABLE_ENTRIES) begin
			send_request(bpat_pkg::OP_ADD, random_text_word(), random_text_word(),
				$urandom);
		end
		send_request(bpat_pkg::OP_ADD, 32'h4646_0000, 32'h3030_0000, 32'h0000_0003);
		send_request(bpat_pkg::OP_REMOVE, table_badge[bpat_pkg::TABLE_ENTRIES-1],
			32'h0, 32'h0);
		send_request(bpat_pkg::OP_CHECK, table_badge[7], table_code[7], $urandom);
	endtask

	// one random request, mostly aimed at badges the table holds
	task automatic random_request();
		bpat_pkg::op_t op;
		logic [31:0] badge;
		logic [31:0] pin;
		int pick;
		int add_pct;
		int idx;
		if (held_count >= bpat_pkg::TABLE_ENTRIES - 2) add_pct = 15;
		else if (held_count <= 2) add_pct = 50;
		else add_pct = 32;
		pick = $urandom_range(99);
		if (pick < add_pct) op = bpat_pkg::OP_ADD;
		else if (pick < add_pct + (100 - add_pct) / 4) op = bpat_pkg::OP_REMOVE;
		else if (pick < add_pct + (100 - add_pct) / 2) op = bpat_pkg::OP_CHANGE;
		else op = bpat_pkg::OP_CHECK;
		pin = random_text_word();
		if ($urandom_range(99) < 12) begin
			// noise: anything at all
			badge = random_text_word();
		end else if (op == bpat_pkg::OP_ADD) begin
			badge = ($urandom_range(9) < 7) ? badge_pool[$urandom_range(5)]
				: random_text_word();
		end else if (held_count > 0 && $urandom_range(9) < 8) begin
			idx = $urandom_range(held_count - 1);
			badge = add_tail_junk(table_badge[idx]);
			if (op == bpat_pkg::OP_CHECK && $urandom_range(99) < 65)
				pin = add_tail_junk(table_code[idx]);
		end else begin
			badge = badge_pool[$urandom_range(5)];
		end
		send_request(op, badge, pin, $urandom);
	endtask

	// random traffic under one idling pattern
	task automatic test_random_traffic(input int count, input int send_pct,
			input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		foreach (badge_pool[i]) badge_pool[i] = random_text_word();
		repeat (count) random_request();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		hold_reqs++;
		repeat (24) random_request();
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 47;
		test_missing_on_empty();
		test_duplicates_and_codes();
		test_word_extremes();
		test_table_full();
		wait_drained();

		test_random_traffic(560, 26, 47);
		test_output_backpressure();
		test_random_traffic(560, 47, 26);
		wait_drained();
		test_random_traffic(560, 0, 0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
